// ----- hw/rtl/kscan_pkg.sv -----
// Package for the key scan debounce and event block.
// Holds shared constants, the event and register codes and the config struct.
// No dependencies.
package kscan_pkg;

  localparam int DEF_HISTORY_DEPTH = 8;
  localparam int DEF_SCAN_WIDTH    = 32;
  localparam int NUM_BUTTONS       = 4;
  localparam int QUEUE_DEPTH       = 2;

  localparam int SCAN_IN_W  = 32;
  localparam int KEY_CNT_W  = 6;
  localparam int NOTE_W     = 7;
  localparam int IDX_W      = 5;
  localparam int KIND_W     = 2;
  localparam int BTN_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  localparam logic [NOTE_W-1:0] NOTE_MAX = 7'd127;

  typedef enum logic [KIND_W-1:0] {
    EV_NOTE_ON     = 2'd0,
    EV_NOTE_OFF    = 2'd1,
    EV_BTN_PRESS   = 2'd2,
    EV_BTN_RELEASE = 2'd3
  } ev_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_COUNT  = 3'd0,
    CFG_NOTE_BASE  = 3'd1,
    CFG_ON_VEL     = 3'd2,
    CFG_OFF_VEL    = 3'd3,
    CFG_PAGE_IDX   = 3'd4,
    CFG_LFO_IDX    = 3'd5,
    CFG_ARP_IDX    = 3'd6,
    CFG_PRESET_IDX = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [KEY_CNT_W-1:0]                key_count;
    logic [NOTE_W-1:0]                   note_base;
    logic [NOTE_W-1:0]                   on_velocity;
    logic [NOTE_W-1:0]                   off_velocity;
    logic [NUM_BUTTONS-1:0][IDX_W-1:0]   fkey_idx;
  } cfg_t;

endpackage

// ----- hw/rtl/kscan_front.sv -----
// Front end: history ring, consensus check and change classification.
// Depends on kscan_pkg; produces one change record per accepted scan for the queue.
module kscan_front import kscan_pkg::*; #(
  parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
  parameter int SCAN_WIDTH    = DEF_SCAN_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cfg_t                              cfg,
  input  logic                              scan_take,
  input  logic [SCAN_IN_W-1:0]              scan_word,
  output logic [SCAN_WIDTH+NUM_BUTTONS-1:0] ev_chg,
  output logic [SCAN_WIDTH+NUM_BUTTONS-1:0] ev_now
);

  localparam int SLOT_W = $clog2(HISTORY_DEPTH);
  localparam int SW_IW  = $clog2(SCAN_WIDTH);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(HISTORY_DEPTH - 1);

  logic [SCAN_WIDTH-1:0] hist_r   [HISTORY_DEPTH];
  logic [SCAN_WIDTH-1:0] hist_nxt [HISTORY_DEPTH];
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic [SCAN_WIDTH-1:0] stable_r, stable_nxt;
  logic [SCAN_WIDTH-1:0] scan, rev, note_en;
  logic [NUM_BUTTONS-1:0] btn_now, btn_was;
  logic                  same;

  always_comb begin
    scan = scan_word[SCAN_WIDTH-1:0] | SCAN_WIDTH'(1);
    for (int k = 0; k < HISTORY_DEPTH; k++) begin
      hist_nxt[k] = (scan_take && slot_r == SLOT_W'(k)) ? scan : hist_r[k];
    end
    same = 1'b1;
    for (int k = 1; k < HISTORY_DEPTH; k++) begin
      if (hist_nxt[k] != hist_nxt[0]) begin
        same = 1'b0;
      end
    end
    for (int b = 0; b < SCAN_WIDTH; b++) begin
      rev[SCAN_WIDTH-1-b] = hist_nxt[0][b];
    end
    stable_nxt = (scan_take && same) ? rev : stable_r;
    slot_nxt   = slot_r;
    if (scan_take) begin
      slot_nxt = (slot_r == SLOT_LAST) ? '0 : slot_r + SLOT_W'(1);
    end

    for (int i = 0; i < SCAN_WIDTH; i++) begin
      note_en[i] = 32'(cfg.key_count) > 32'(i);
    end
    // A function key index beyond the scan reads as pressed (0) in both states.
    for (int j = 0; j < NUM_BUTTONS; j++) begin
      btn_now[j] = 1'b0;
      btn_was[j] = 1'b0;
      if (32'(cfg.fkey_idx[j]) < SCAN_WIDTH) begin
        btn_now[j] = stable_nxt[cfg.fkey_idx[j][SW_IW-1:0]];
        btn_was[j] = stable_r[cfg.fkey_idx[j][SW_IW-1:0]];
      end
    end
    ev_chg = {btn_now ^ btn_was, (stable_nxt ^ stable_r) & note_en};
    ev_now = {btn_now, stable_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
        hist_r[k] <= '1;
      end
      slot_r   <= '0;
      stable_r <= '1;
    end else begin
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
        hist_r[k] <= hist_nxt[k];
      end
      slot_r   <= slot_nxt;
      stable_r <= stable_nxt;
    end
  end

endmodule

// ----- hw/rtl/kscan_queue.sv -----
// Small FIFO that decouples the front end from the event walker.
// Depends on kscan_pkg for its default width and depth.
module kscan_queue import kscan_pkg::*; #(
  parameter int WIDTH = 2 * (DEF_SCAN_WIDTH + NUM_BUTTONS),
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = cnt_r == CNT_W'(DEPTH);
  assign pop_valid = cnt_r != '0;
  assign pop_data  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- hw/rtl/kscan_back.sv -----
// Back end: walks one change record bit by bit and emits events.
// Depends on kscan_pkg; drives the registered result channel.
module kscan_back import kscan_pkg::*; #(
  parameter int SCAN_WIDTH = DEF_SCAN_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cfg_t                              cfg,
  input  logic                              rec_valid,
  input  logic [SCAN_WIDTH+NUM_BUTTONS-1:0] rec_chg,
  input  logic [SCAN_WIDTH+NUM_BUTTONS-1:0] rec_now,
  output logic                              rec_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [KIND_W-1:0]                 out_event_kind,
  output logic [NOTE_W-1:0]                 out_note_number,
  output logic [NOTE_W-1:0]                 out_velocity,
  output logic [BTN_W-1:0]                  out_button_id,
  output logic                              out_last_event
);

  localparam int EV_W  = SCAN_WIDTH + NUM_BUTTONS;
  localparam int POS_W = $clog2(EV_W);
  localparam logic [POS_W-1:0] NOTE_END = POS_W'(SCAN_WIDTH);

  logic             busy_r, busy_nxt;
  logic [EV_W-1:0]  mask_r, mask_nxt, now_r, now_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             step, emit;
  logic [NOTE_W+1:0] note_sum;

  logic              valid_r, valid_nxt;
  ev_kind_t          kind_r, kind_nxt;
  logic [NOTE_W-1:0] note_r, note_nxt, vel_r, vel_nxt;
  logic [BTN_W-1:0]  btn_r, btn_nxt;
  logic              last_r, last_nxt;

  always_comb begin
    step     = busy_r && (!valid_r || !out_stall);
    emit     = step && mask_r[0];
    rec_pop  = !busy_r && rec_valid;
    note_sum = (NOTE_W+2)'(pos_r) + (NOTE_W+2)'(cfg.note_base);

    busy_nxt = busy_r;
    mask_nxt = mask_r;
    now_nxt  = now_r;
    pos_nxt  = pos_r;
    if (rec_pop) begin
      busy_nxt = |rec_chg;
      mask_nxt = rec_chg;
      now_nxt  = rec_now;
      pos_nxt  = '0;
    end else if (step) begin
      mask_nxt = mask_r >> 1;
      now_nxt  = now_r >> 1;
      pos_nxt  = pos_r + POS_W'(1);
      busy_nxt = |mask_r[EV_W-1:1];
    end

    valid_nxt = valid_r && out_stall;
    kind_nxt  = kind_r;
    note_nxt  = note_r;
    vel_nxt   = vel_r;
    btn_nxt   = btn_r;
    last_nxt  = last_r;
    if (emit) begin
      valid_nxt = 1'b1;
      last_nxt  = ~|mask_r[EV_W-1:1];
      if (pos_r < NOTE_END) begin
        kind_nxt = now_r[0] ? EV_NOTE_OFF : EV_NOTE_ON;
        note_nxt = (note_sum > (NOTE_W+2)'(NOTE_MAX)) ? NOTE_MAX : note_sum[NOTE_W-1:0];
        vel_nxt  = now_r[0] ? cfg.off_velocity : cfg.on_velocity;
        btn_nxt  = '0;
      end else begin
        kind_nxt = now_r[0] ? EV_BTN_RELEASE : EV_BTN_PRESS;
        note_nxt = '0;
        vel_nxt  = '0;
        btn_nxt  = BTN_W'(pos_r - NOTE_END);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mask_r <= mask_nxt;
    now_r  <= now_nxt;
    pos_r  <= pos_nxt;
    kind_r <= kind_nxt;
    note_r <= note_nxt;
    vel_r  <= vel_nxt;
    btn_r  <= btn_nxt;
    last_r <= last_nxt;
  end

  assign out_valid       = valid_r;
  assign out_event_kind  = kind_r;
  assign out_note_number = note_r;
  assign out_velocity    = vel_r;
  assign out_button_id   = btn_r;
  assign out_last_event  = last_r;

endmodule

// ----- hw/rtl/key_scan_debounce_events_core.sv -----
// Key scan debouncer and event generator. A scan is accepted whenever the
// two-entry change queue has room; the front end updates the history ring and
// the debounced key state in that same cycle. The back end loads each record
// from the queue and then walks the SCAN_WIDTH note positions and four function
// keys one bit per cycle while the result channel is not stalled, stopping
// after the highest pending event, so it emits at most one event per cycle. A
// scan that changes nothing produces no result. Configuration writes are
// always ready.
// Depends on kscan_pkg, kscan_front, kscan_queue and kscan_back.
module key_scan_debounce_events_core import kscan_pkg::*; #(
  parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
  parameter int SCAN_WIDTH    = DEF_SCAN_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SCAN_IN_W-1:0]  in_scan_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [KIND_W-1:0]     out_event_kind,
  output logic [NOTE_W-1:0]     out_note_number,
  output logic [NOTE_W-1:0]     out_velocity,
  output logic [BTN_W-1:0]      out_button_id,
  output logic                  out_last_event
);

  localparam int EV_W = SCAN_WIDTH + NUM_BUTTONS;

  cfg_t            cfg_r, cfg_nxt;
  logic            scan_take, q_full, q_pop, q_valid;
  logic [EV_W-1:0] ev_chg, ev_now, rec_chg, rec_now;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_KEY_COUNT:  cfg_nxt.key_count    = cfg_data[KEY_CNT_W-1:0];
        CFG_NOTE_BASE:  cfg_nxt.note_base    = cfg_data[NOTE_W-1:0];
        CFG_ON_VEL:     cfg_nxt.on_velocity  = cfg_data[NOTE_W-1:0];
        CFG_OFF_VEL:    cfg_nxt.off_velocity = cfg_data[NOTE_W-1:0];
        CFG_PAGE_IDX:   cfg_nxt.fkey_idx[0]  = cfg_data[IDX_W-1:0];
        CFG_LFO_IDX:    cfg_nxt.fkey_idx[1]  = cfg_data[IDX_W-1:0];
        CFG_ARP_IDX:    cfg_nxt.fkey_idx[2]  = cfg_data[IDX_W-1:0];
        CFG_PRESET_IDX: cfg_nxt.fkey_idx[3]  = cfg_data[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key_count    <= KEY_CNT_W'(27);
      cfg_r.note_base    <= NOTE_W'(48);
      cfg_r.on_velocity  <= NOTE_W'(127);
      cfg_r.off_velocity <= NOTE_W'(0);
      cfg_r.fkey_idx[0]  <= IDX_W'(27);
      cfg_r.fkey_idx[1]  <= IDX_W'(28);
      cfg_r.fkey_idx[2]  <= IDX_W'(29);
      cfg_r.fkey_idx[3]  <= IDX_W'(30);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_stall  = q_full;
  assign scan_take = in_valid && !q_full;

  kscan_front #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .SCAN_WIDTH   (SCAN_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .scan_take(scan_take),
    .scan_word(in_scan_word),
    .ev_chg   (ev_chg),
    .ev_now   (ev_now)
  );

  kscan_queue #(
    .WIDTH(2 * EV_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (scan_take),
    .push_data({ev_now, ev_chg}),
    .full     (q_full),
    .pop      (q_pop),
    .pop_valid(q_valid),
    .pop_data ({rec_now, rec_chg})
  );

  kscan_back #(
    .SCAN_WIDTH(SCAN_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .rec_valid      (q_valid),
    .rec_chg        (rec_chg),
    .rec_now        (rec_now),
    .rec_pop        (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_event_kind (out_event_kind),
    .out_note_number(out_note_number),
    .out_velocity   (out_velocity),
    .out_button_id  (out_button_id),
    .out_last_event (out_last_event)
  );

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for key_scan_debounce_events_core: drives key scans and
// register writes, predicts the debounced key events and checks every event.
// Depends on kscan_pkg and the core RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import kscan_pkg::*;

  localparam int DEPTH          = DEF_HISTORY_DEPTH;
  localparam int WIDTH          = DEF_SCAN_WIDTH;
  localparam int SETTLE_CYCLES  = 100;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct {
    ev_kind_t          kind;
    logic [NOTE_W-1:0] note;
    logic [NOTE_W-1:0] vel;
    logic [BTN_W-1:0]  btn;
    logic              last;
  } key_event_t;

  // Tracks the debounce ring and the key state and holds the events still owed.
  class key_event_board;
    logic [KEY_CNT_W-1:0] key_count;
    logic [NOTE_W-1:0]    note_base;
    logic [NOTE_W-1:0]    on_vel;
    logic [NOTE_W-1:0]    off_vel;
    logic [IDX_W-1:0]     fkey [NUM_BUTTONS];
    logic [WIDTH-1:0]     history [DEPTH];
    int                   slot;
    logic [WIDTH-1:0]     stable_keys;
    logic [WIDTH-1:0]     previous_keys;
    key_event_t           owed_events [$];
    int                   mismatches;
    int                   events_checked;
    int                   key_changes;

    function new();
      key_count = 6'd27;
      note_base = 7'd48;
      on_vel    = 7'd127;
      off_vel   = 7'd0;
      fkey[0]   = 5'd27;
      fkey[1]   = 5'd28;
      fkey[2]   = 5'd29;
      fkey[3]   = 5'd30;
      foreach (history[i]) history[i] = '1;
      slot = 0;
      stable_keys = '1;
      previous_keys = '1;
      mismatches = 0;
      events_checked = 0;
      key_changes = 0;
    endfunction

    function void set_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
      case (r)
        CFG_KEY_COUNT:  key_count = v[KEY_CNT_W-1:0];
        CFG_NOTE_BASE:  note_base = v;
        CFG_ON_VEL:     on_vel = v;
        CFG_OFF_VEL:    off_vel = v;
        CFG_PAGE_IDX:   fkey[0] = v[IDX_W-1:0];
        CFG_LFO_IDX:    fkey[1] = v[IDX_W-1:0];
        CFG_ARP_IDX:    fkey[2] = v[IDX_W-1:0];
        CFG_PRESET_IDX: fkey[3] = v[IDX_W-1:0];
        default: ;
      endcase
    endfunction

    function key_event_t make_event(ev_kind_t k, int note, logic [NOTE_W-1:0] vel, int btn);
      key_event_t e;
      e.kind = k;
      e.note = note[NOTE_W-1:0];
      e.vel  = vel;
      e.btn  = btn[BTN_W-1:0];
      e.last = 1'b0;
      return e;
    endfunction

    function void note_scan(logic [SCAN_IN_W-1:0] raw);
      key_event_t       evs [$];
      key_event_t       e;
      logic [WIDTH-1:0] w;
      logic             now_bit, was_bit;
      bit               all_same;
      int               notes, nt, i;
      w = raw[WIDTH-1:0] | 1;
      history[slot] = w;
      slot = (slot == DEPTH - 1) ? 0 : slot + 1;
      all_same = 1;
      for (i = 1; i < DEPTH; i++)
        if (history[i] != history[0]) all_same = 0;
      if (all_same) begin
        for (i = 0; i < WIDTH; i++) stable_keys[WIDTH-1-i] = history[0][i];
      end
      if (stable_keys != previous_keys) key_changes++;

      notes = (key_count > WIDTH) ? WIDTH : key_count;
      for (i = 0; i < notes; i++) begin
        nt = i + note_base;
        if (nt > NOTE_MAX) nt = NOTE_MAX;
        if (!stable_keys[i] && previous_keys[i])
          evs.push_back(make_event(EV_NOTE_ON, nt, on_vel, 0));
        else if (stable_keys[i] && !previous_keys[i])
          evs.push_back(make_event(EV_NOTE_OFF, nt, off_vel, 0));
      end
      for (i = 0; i < NUM_BUTTONS; i++) begin
        now_bit = (fkey[i] < WIDTH) ? stable_keys[fkey[i]] : 1'b0;
        was_bit = (fkey[i] < WIDTH) ? previous_keys[fkey[i]] : 1'b0;
        if (!now_bit && was_bit)
          evs.push_back(make_event(EV_BTN_PRESS, 0, '0, i));
        else if (now_bit && !was_bit)
          evs.push_back(make_event(EV_BTN_RELEASE, 0, '0, i));
      end
      previous_keys = stable_keys;

      if (evs.size() > 0) begin
        e = evs.pop_back();
        e.last = 1'b1;
        evs.push_back(e);
      end
      foreach (evs[k]) owed_events.push_back(evs[k]);
    endfunction

    function void check_event(logic [KIND_W-1:0] kind, logic [NOTE_W-1:0] note,
                              logic [NOTE_W-1:0] vel, logic [BTN_W-1:0] btn, logic last);
      key_event_t e;
      events_checked++;
      if (owed_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected event kind=%0d note=%0d vel=%0d btn=%0d last=%0d",
                   kind, note, vel, btn, last);
      end else begin
        e = owed_events.pop_front();
        if (kind !== e.kind || note !== e.note || vel !== e.vel || btn !== e.btn ||
            last !== e.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: event %0d expected kind=%0d note=%0d vel=%0d btn=%0d last=%0d",
                     events_checked, e.kind, e.note, e.vel, e.btn, e.last);
            $display("       got kind=%0d note=%0d vel=%0d btn=%0d last=%0d",
                     kind, note, vel, btn, last);
          end
        end
      end
    endfunction

    function int left();
      return owed_events.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [SCAN_IN_W-1:0]  in_scan_word = '1;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [KIND_W-1:0]     out_event_kind;
  logic [NOTE_W-1:0]     out_note_number;
  logic [NOTE_W-1:0]     out_velocity;
  logic [BTN_W-1:0]      out_button_id;
  logic                  out_last_event;

  key_event_board board = new();

  int               scans_sent = 0;
  int               settings_used = 1;
  int               quiet_cycles = 0;
  int               hold_left = 0;
  int               pick;
  bit               stall_mode = 0;
  bit               no_gaps = 0;
  logic [WIDTH-1:0] scan_target = '1;

  key_scan_debounce_events_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_scan_word    (in_scan_word),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_kind  (out_event_kind),
    .out_note_number (out_note_number),
    .out_velocity    (out_velocity),
    .out_button_id   (out_button_id),
    .out_last_event  (out_last_event)
  );

  always #5ns clk = ~clk;

  // Result-side back-pressure: short stalls, a few long ones, and free-running stretches.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        stall_mode = 0;
        hold_left = $urandom_range(20, 80);
      end else if (pick < 12) begin
        stall_mode = 1;
        hold_left = $urandom_range(15, 50);
      end else if (pick < 45) begin
        stall_mode = 1;
        hold_left = $urandom_range(0, 2);
      end else begin
        stall_mode = 0;
        hold_left = $urandom_range(0, 3);
      end
    end
    out_stall <= stall_mode;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_event(out_event_kind, out_note_number, out_velocity, out_button_id,
                        out_last_event);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no request accepted for %0d cycles", quiet_cycles);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_scan(logic [SCAN_IN_W-1:0] word);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      in_scan_word = $urandom;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_scan_word = word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_scan(word);
    scans_sent++;
  endtask

  task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = r;
    cfg_data = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_reg(r, v);
  endtask

  // Lets every owed event drain, then gives the back end time to finish scans
  // that produced nothing.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (board.left() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(logic [CFG_DATA_W-1:0] kc, logic [CFG_DATA_W-1:0] base,
                               logic [CFG_DATA_W-1:0] onv, logic [CFG_DATA_W-1:0] offv,
                               logic [CFG_DATA_W-1:0] page, logic [CFG_DATA_W-1:0] lfo,
                               logic [CFG_DATA_W-1:0] arp, logic [CFG_DATA_W-1:0] preset);
    drain();
    write_reg(CFG_KEY_COUNT, kc);
    write_reg(CFG_NOTE_BASE, base);
    write_reg(CFG_ON_VEL, onv);
    write_reg(CFG_OFF_VEL, offv);
    write_reg(CFG_PAGE_IDX, page);
    write_reg(CFG_LFO_IDX, lfo);
    write_reg(CFG_ARP_IDX, arp);
    write_reg(CFG_PRESET_IDX, preset);
    @(negedge clk);
    cfg_valid = 1'b0;
    settings_used++;
  endtask

  // Mostly steady key patterns held long enough to pass the debounce, some with
  // a bounce inside, plus bursts of pure noise.
  task automatic run_scans(int count);
    int sent, reps, r;
    sent = 0;
    while (sent < count) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 15) begin
        reps = $urandom_range(1, 4);
        repeat (reps) send_scan($urandom);
        sent += reps;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          scan_target ^= 32'h1 << $urandom_range(0, 31);
          if ($urandom_range(0, 1)) scan_target ^= 32'h1 << $urandom_range(0, 31);
        end else if (r < 60) begin
          scan_target = $urandom;
        end else if (r < 70) begin
          scan_target = '0;
        end else if (r < 80) begin
          scan_target = '1;
        end else if (r < 90) begin
          scan_target = $urandom | $urandom | $urandom;
        end else begin
          scan_target = $urandom & $urandom;
        end
        if ($urandom_range(0, 3) == 0) begin
          reps = $urandom_range(1, 4);
          repeat (reps) send_scan(scan_target);
          send_scan(scan_target ^ (32'h1 << $urandom_range(1, 31)));
          sent += reps + 1;
        end
        reps = 8 + $urandom_range(0, 3);
        repeat (reps) send_scan(scan_target);
        sent += reps;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Every key down at once, then every key up, with the reset settings.
    repeat (DEPTH) send_scan(32'h0000_0000);
    repeat (DEPTH) send_scan(32'hFFFF_FFFF);
    scan_target = '1;
    run_scans(60);

    // Lowest settings: no note keys, every function key on the same bit.
    apply_setting(7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0);
    repeat (DEPTH) send_scan(32'h0000_0000);
    run_scans(60);

    // Full note range at the top base; function keys overlap notes and each other.
    apply_setting(7'd32, 7'd96, 7'd127, 7'd127, 7'd31, 7'd0, 7'd0, 7'd16);
    run_scans(80);

    // Oversized key count and a base that pushes notes past the top.
    apply_setting(7'd63, 7'd127, 7'd1, 7'd126, 7'd5, 7'd5, 7'd20, 7'd31);
    run_scans(80);

    repeat (2) begin
      apply_setting(CFG_DATA_W'($urandom_range(0, 32)), CFG_DATA_W'($urandom_range(0, 96)),
                    CFG_DATA_W'($urandom_range(0, 127)), CFG_DATA_W'($urandom_range(0, 127)),
                    CFG_DATA_W'($urandom_range(0, 31)), CFG_DATA_W'($urandom_range(0, 31)),
                    CFG_DATA_W'($urandom_range(0, 31)), CFG_DATA_W'($urandom_range(0, 31)));
      run_scans(70);
    end

    drain();
    $display("Run covered %0d scans, %0d debounced key changes and %0d events",
             scans_sent, board.key_changes, board.events_checked);
    $display("under %0d register settings; mismatches: %0d, events still owed: %0d",
             settings_used, board.mismatches, board.left());
    if (board.mismatches == 0 && board.left() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
